### rtl/bbbc_pkg.sv
// ----------------------------------------------------------------------------
// bbbc_pkg
// Shared types and constants of the bounding box blob clusterer.
// ----------------------------------------------------------------------------
package bbbc_pkg;
    localparam int NUM_SLOTS_DEF = 16;
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic mode;
        logic [7:0] col;
        logic [7:0] row;
        logic signed [15:0] real_x;
        logic signed [15:0] real_y;
    } t_item;

    typedef struct packed {
        logic [3:0]  slot;
        logic        table_full;
        logic [3:0]  merges;
        logic [4:0]  active_count;
        logic        largest_valid;
        logic [3:0]  largest_slot;
        logic [15:0] largest_area;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic place;
        logic report;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic report_done;
    } t_status;
endpackage

### rtl/bbbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbbc_ctrl
// Sequencer: load, scan slots, place new blob, report pass, hand result out (clear items skip scan and place).
// ----------------------------------------------------------------------------
module bbbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_mode,
    output bbbc_pkg::t_cmd    o_cmd,
    input  bbbc_pkg::t_status i_status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_REP   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.clear  = accept && (i_mode == bbbc_pkg::MODE_CLEAR);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.place  = (r_state == S_PLACE);
        o_cmd.report = (r_state == S_REP);
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = (i_mode == bbbc_pkg::MODE_CLEAR) ? S_REP : S_SCAN;
            S_SCAN:  if (i_status.scan_done) n_state = S_PLACE;
            S_PLACE: n_state = S_REP;
            S_REP:   if (i_status.report_done) n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

### rtl/bbbc_datapath.sv
// ----------------------------------------------------------------------------
// bbbc_datapath
// Slot table and one-slot-per-cycle match, merge and report engine.
// ----------------------------------------------------------------------------
module bbbc_datapath #(
    parameter int NUM_SLOTS = bbbc_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbbc_pkg::t_cmd    i_cmd,
    input  bbbc_pkg::t_item   i_item,
    output bbbc_pkg::t_status o_status,
    output bbbc_pkg::t_result o_result
);
    localparam int IW = $clog2(NUM_SLOTS);

    logic [7:0]  r_left [NUM_SLOTS];
    logic [7:0]  r_right[NUM_SLOTS];
    logic [7:0]  r_lower[NUM_SLOTS];
    logic [7:0]  r_upper[NUM_SLOTS];
    logic [15:0] r_cnt  [NUM_SLOTS];
    logic signed [15:0] r_mnx[NUM_SLOTS];
    logic signed [15:0] r_mxx[NUM_SLOTS];
    logic signed [15:0] r_mny[NUM_SLOTS];
    logic signed [15:0] r_mxy[NUM_SLOTS];

    bbbc_pkg::t_item r_item;
    logic [IW-1:0] r_idx, r_first, r_free;
    logic          r_found, r_has_free, r_full;
    logic [3:0]    r_merges;
    logic [4:0]    r_active;
    logic          r_bvalid;
    logic [IW-1:0] r_bslot;
    logic [16:0]   r_barea;

    logic        hit, last;
    logic [8:0]  w, h;
    logic [17:0] area;
    logic [16:0] csum;

    assign last = (r_idx == IW'(NUM_SLOTS - 1));
    assign hit  = (r_cnt[r_idx] != 16'd0)
        && ({1'b0, r_item.col} + 9'd1 >= {1'b0, r_left[r_idx]})
        && ({1'b0, r_item.col} <= {1'b0, r_right[r_idx]} + 9'd1)
        && ({1'b0, r_item.row} + 9'd1 >= {1'b0, r_lower[r_idx]})
        && ({1'b0, r_item.row} <= {1'b0, r_upper[r_idx]} + 9'd1);
    assign w    = {1'b0, r_right[r_idx]} - {1'b0, r_left[r_idx]} + 9'd1;
    assign h    = {1'b0, r_upper[r_idx]} - {1'b0, r_lower[r_idx]} + 9'd1;
    assign area = w * h;
    assign csum = {1'b0, r_cnt[r_first]} + {1'b0, r_cnt[r_idx]};

    assign o_status.scan_done   = i_cmd.scan && last;
    assign o_status.report_done = i_cmd.report && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_left[i] <= '0; r_right[i] <= '0; r_lower[i] <= '0;
                r_upper[i] <= '0; r_cnt[i] <= '0;
            end
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_item     <= i_item;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
            r_first    <= '0;
            r_free     <= '0;
            r_full     <= 1'b0;
            r_merges   <= '0;
            r_active   <= '0;
            r_bvalid   <= 1'b0;
            r_bslot    <= '0;
            r_barea    <= '0;
            if (i_cmd.clear) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    r_left[i] <= '0; r_right[i] <= '0; r_lower[i] <= '0;
                    r_upper[i] <= '0; r_cnt[i] <= '0;
                end
            end
        end else if (i_cmd.scan) begin
            r_idx <= last ? '0 : r_idx + IW'(1);
            if (r_cnt[r_idx] == 16'd0 && !r_has_free) begin
                r_has_free <= 1'b1;
                r_free     <= r_idx;
            end
            if (hit && !r_found) begin
                r_found <= 1'b1;
                r_first <= r_idx;
                if (r_item.col < r_left[r_idx])  r_left[r_idx]  <= r_item.col;
                if (r_item.col > r_right[r_idx]) r_right[r_idx] <= r_item.col;
                if (r_item.row < r_lower[r_idx]) r_lower[r_idx] <= r_item.row;
                if (r_item.row > r_upper[r_idx]) r_upper[r_idx] <= r_item.row;
                if (r_item.real_x < r_mnx[r_idx]) r_mnx[r_idx] <= r_item.real_x;
                if (r_item.real_x > r_mxx[r_idx]) r_mxx[r_idx] <= r_item.real_x;
                if (r_item.real_y < r_mny[r_idx]) r_mny[r_idx] <= r_item.real_y;
                if (r_item.real_y > r_mxy[r_idx]) r_mxy[r_idx] <= r_item.real_y;
                if (r_cnt[r_idx] != 16'hFFFF) r_cnt[r_idx] <= r_cnt[r_idx] + 16'd1;
            end else if (hit) begin
                if (r_left[r_idx] < r_left[r_first])   r_left[r_first]  <= r_left[r_idx];
                if (r_right[r_idx] > r_right[r_first]) r_right[r_first] <= r_right[r_idx];
                if (r_lower[r_idx] < r_lower[r_first]) r_lower[r_first] <= r_lower[r_idx];
                if (r_upper[r_idx] > r_upper[r_first]) r_upper[r_first] <= r_upper[r_idx];
                if (r_mnx[r_idx] < r_mnx[r_first]) r_mnx[r_first] <= r_mnx[r_idx];
                if (r_mxx[r_idx] > r_mxx[r_first]) r_mxx[r_first] <= r_mxx[r_idx];
                if (r_mny[r_idx] < r_mny[r_first]) r_mny[r_first] <= r_mny[r_idx];
                if (r_mxy[r_idx] > r_mxy[r_first]) r_mxy[r_first] <= r_mxy[r_idx];
                r_cnt[r_first] <= csum[16] ? 16'hFFFF : csum[15:0];
                r_left[r_idx] <= '0; r_right[r_idx] <= '0; r_lower[r_idx] <= '0;
                r_upper[r_idx] <= '0; r_cnt[r_idx] <= '0;
                if (r_merges != 4'd15) r_merges <= r_merges + 4'd1;
                // freed slot is later than any free one seen so far
                if (!r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= r_idx;
                end
            end
        end else if (i_cmd.place) begin
            if (!r_found) begin
                if (r_has_free) begin
                    r_first <= r_free;
                    r_left[r_free] <= r_item.col;  r_right[r_free] <= r_item.col;
                    r_lower[r_free] <= r_item.row; r_upper[r_free] <= r_item.row;
                    r_mnx[r_free] <= r_item.real_x; r_mxx[r_free] <= r_item.real_x;
                    r_mny[r_free] <= r_item.real_y; r_mxy[r_free] <= r_item.real_y;
                    r_cnt[r_free] <= 16'd1;
                end else begin
                    r_full <= 1'b1;
                end
            end
        end else if (i_cmd.report) begin
            r_idx <= last ? '0 : r_idx + IW'(1);
            if (r_cnt[r_idx] != 16'd0) begin
                if (r_active != 5'd31) r_active <= r_active + 5'd1;
                if ({1'b0, area[16:0]} > {1'b0, r_barea} || area[17]) begin
                    if (area[17:0] > {1'b0, r_barea}) begin
                        r_barea  <= area[16:0];
                        r_bslot  <= r_idx;
                        r_bvalid <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_result               = '0;
        o_result.slot          = 4'(r_full ? '0 : r_first);
        o_result.table_full    = r_full;
        o_result.merges        = r_merges;
        o_result.active_count  = r_active;
        o_result.largest_valid = r_bvalid;
        o_result.largest_slot  = 4'(r_bslot);
        o_result.largest_area  = r_barea[16] ? 16'hFFFF : r_barea[15:0];
    end
endmodule

### rtl/bounding_box_blob_clusterer_unit.sv
// ----------------------------------------------------------------------------
// bounding_box_blob_clusterer_unit
// Online blob clustering over a table of grid bounding boxes.
// ----------------------------------------------------------------------------
// Add item: load, scan of every slot, place, report pass, then result;
// clear item: load, report pass, then result. One slot read per cycle sets the rate.
// One item at a time; next accept once the result is taken.
// Synchronous active-low reset frees all slots.
module bounding_box_blob_clusterer_unit #(
    parameter int NUM_SLOTS = bbbc_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // col, row, real_x, real_y
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // slot, table_full, merges, active_count,
                                       // largest_valid, largest_slot, largest_area
);
    bbbc_pkg::t_cmd    cmd;
    bbbc_pkg::t_status status;
    bbbc_pkg::t_item   item;
    bbbc_pkg::t_result res;

    assign item.mode   = s_axis_tuser;
    assign item.col    = s_axis_tdata[7:0];
    assign item.row    = s_axis_tdata[15:8];
    assign item.real_x = s_axis_tdata[31:16];
    assign item.real_y = s_axis_tdata[47:32];

    bbbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_mode(s_axis_tuser), .o_cmd(cmd), .i_status(status)
    );

    bbbc_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(item),
        .o_status(status), .o_result(res)
    );

    assign m_axis_tdata = {5'd0, res.largest_area, res.largest_slot, res.largest_valid,
                           res.active_count, res.merges, res.table_full, res.slot};
endmodule

### rtl/bbbc_checker.sv
// ----------------------------------------------------------------------------
// bbbc_sva
// Port-level checks of the blob clusterer.
// ----------------------------------------------------------------------------
module bbbc_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("accept while result pending");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("full with nonzero slot");
    a_lv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14] == (m_axis_tdata[13:9] != 5'd0)))
        else $error("largest_valid disagrees with active count");
endmodule

bind bounding_box_blob_clusterer_unit bbbc_sva u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
